// ===== design/mlmf_pkg.sv =====
package mlmf_pkg;

  localparam int unsigned DEF_SCAN_WIDTH = 4;
  localparam int unsigned DEF_MASK_WIDTH = 32;
  localparam int unsigned DEF_MAX_LEVELS = 7;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned ENTRY_W  = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CHUNK_W  = 8;
  localparam int unsigned INDEX_W  = 32;
  localparam int unsigned CFG_W    = 3;
  localparam int unsigned TABLE_AW = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_SCAN  = 2'd2
  } mode_e;

  // table write request from the item side to the table memory
  typedef struct packed {
    logic                en;
    logic [LEVEL_W-1:0]  level;
    logic [TABLE_AW-1:0] addr;
    logic [WORD_W-1:0]   data;
  } tbl_wr_t;

endpackage

// ===== design/mlmf_item_if.sv =====
interface mlmf_item_if;
  import mlmf_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [LEVEL_W-1:0] level;
  logic [ENTRY_W-1:0] entry;
  logic [WORD_W-1:0]  table_word;
  logic [CHUNK_W-1:0] chunk;
  logic [INDEX_W-1:0] start_index;
  logic [INDEX_W-1:0] stop_index;

  modport source (
    output valid, mode, level, entry, table_word, chunk, start_index, stop_index,
    input  ready
  );

  modport sink (
    input  valid, mode, level, entry, table_word, chunk, start_index, stop_index,
    output ready
  );

endinterface

// ===== design/mlmf_hit_if.sv =====
interface mlmf_hit_if;
  import mlmf_pkg::*;

  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  hit_mask;
  logic [INDEX_W-1:0] hit_chunk;

  modport source (
    output valid, hit_mask, hit_chunk,
    input  ready
  );

  modport sink (
    input  valid, hit_mask, hit_chunk,
    output ready
  );

endinterface

// ===== design/mlmf_table_ram.sv =====
module mlmf_table_ram #(
  parameter int unsigned MASK_WIDTH = mlmf_pkg::DEF_MASK_WIDTH,
  parameter int unsigned MAX_LEVELS = mlmf_pkg::DEF_MAX_LEVELS
) (
  input  logic                                 clk_i,
  input  mlmf_pkg::tbl_wr_t                    wr_i,
  input  logic                                 rd_en_i,
  input  logic [mlmf_pkg::TABLE_AW-1:0]        rd_addr_i,
  output logic [MAX_LEVELS*MASK_WIDTH-1:0]     rd_data_o
);
  import mlmf_pkg::*;

  localparam int unsigned ROW_W = MAX_LEVELS * MASK_WIDTH;
  localparam int unsigned DEPTH = 1 << TABLE_AW;

  // one row per table entry, one lane per level
  logic [ROW_W-1:0] mem_q [DEPTH];
  logic [ROW_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < MAX_LEVELS; l++) begin
      if (wr_i.en && (wr_i.level == LEVEL_W'(l))) begin
        mem_q[wr_i.addr][l*MASK_WIDTH +: MASK_WIDTH] <= MASK_WIDTH'(wr_i.data);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/multi_level_motif_mask_filter_unit.sv =====
// Hit path: a scan beat that is accepted has its table row read on the accept edge;
// the mask update then goes into the output register when stage 1 advances, which a
// held output register can delay.
// Throughput: one beat per cycle; the per-entry table row read and the mask
// registers keep pace, and only a held output register stalls the input.
// Reset (async, active low): masks, position and stop bound clear, scan open,
// num_levels = 1; table contents stay undefined until loaded, no clearing pass.
module multi_level_motif_mask_filter_unit #(
  parameter int unsigned SCAN_WIDTH = mlmf_pkg::DEF_SCAN_WIDTH,
  parameter int unsigned MASK_WIDTH = mlmf_pkg::DEF_MASK_WIDTH,
  parameter int unsigned MAX_LEVELS = mlmf_pkg::DEF_MAX_LEVELS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mlmf_pkg::CFG_W-1:0] cfg_wdata_i,
  mlmf_item_if.sink                  item_i,
  mlmf_hit_if.source                 hit_o
);
  import mlmf_pkg::*;

  localparam int unsigned IDX_BITS = (2 * SCAN_WIDTH < TABLE_AW) ? 2 * SCAN_WIDTH : TABLE_AW;
  localparam logic [TABLE_AW-1:0] IDX_MASK = TABLE_AW'((1 << IDX_BITS) - 1);
  localparam logic [CFG_W:0] LVL_MAX = (CFG_W + 1)'(MAX_LEVELS);

  logic [CFG_W-1:0] num_levels_q;
  logic [CFG_W:0]   n_eff;

  logic [INDEX_W-1:0] pos_q, pos_d;
  logic [INDEX_W-1:0] stop_q, stop_d;
  logic               done_q, done_d;

  logic               s1_valid_q, s1_valid_d;
  mode_e              s1_mode_q;
  logic [INDEX_W-1:0] s1_here_q;

  logic [MASK_WIDTH-1:0] mask_q [MAX_LEVELS];
  logic [MASK_WIDTH-1:0] mask_new [MAX_LEVELS];
  logic [MASK_WIDTH-1:0] top_mask;

  logic                  hit_valid_q, hit_valid_d;
  logic [WORD_W-1:0]     hit_mask_q;
  logic [INDEX_W-1:0]    hit_chunk_q;

  logic [MAX_LEVELS*MASK_WIDTH-1:0] rd_row;
  tbl_wr_t                          tbl_wr;
  logic                             rd_en;

  mode_e in_mode;
  logic  accept;
  logic  s1_adv;
  logic  s1_fire;
  logic  scan_ok;
  logic  hit_take;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_levels_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      num_levels_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    n_eff = {1'b0, num_levels_q};
    if (n_eff == '0) n_eff = (CFG_W + 1)'(1);
    if (n_eff > LVL_MAX) n_eff = LVL_MAX;
  end

  // ---------------- handshake ----------------
  assign hit_take = hit_valid_q && hit_o.ready;
  assign s1_adv   = !s1_valid_q || !hit_valid_q || hit_o.ready;
  assign s1_fire  = s1_valid_q && s1_adv;
  assign item_i.ready = s1_adv;
  assign accept   = item_i.valid && s1_adv;
  assign in_mode  = mode_e'(item_i.mode);
  assign scan_ok  = !done_q && (pos_q <= stop_q);

  // ---------------- stage 0: position control and table access ----------------
  always_comb begin
    pos_d      = pos_q;
    stop_d     = stop_q;
    done_d     = done_q;
    s1_valid_d = s1_adv ? 1'b0 : s1_valid_q;
    rd_en      = 1'b0;
    tbl_wr     = '0;
    if (accept) begin
      case (in_mode)
        MODE_LOAD: begin
          tbl_wr.en    = 1'b1;
          tbl_wr.level = item_i.level;
          tbl_wr.addr  = item_i.entry;
          tbl_wr.data  = item_i.table_word;
        end
        MODE_START: begin
          pos_d      = item_i.start_index;
          stop_d     = item_i.stop_index;
          done_d     = 1'b0;
          s1_valid_d = 1'b1;
        end
        MODE_SCAN: begin
          if (scan_ok) begin
            rd_en      = 1'b1;
            s1_valid_d = 1'b1;
            if (pos_q == stop_q) done_d = 1'b1;
            else pos_d = pos_q + INDEX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      stop_q     <= '0;
      done_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      stop_q     <= stop_d;
      done_q     <= done_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= in_mode;
      s1_here_q <= pos_q;
    end
  end

  mlmf_table_ram #(
    .MASK_WIDTH (MASK_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_table_ram (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (item_i.chunk[TABLE_AW-1:0] & IDX_MASK),
    .rd_data_o (rd_row)
  );

  // ---------------- stage 1: mask chain update ----------------
  always_comb begin
    top_mask = '0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      if (k == 0) mask_new[k] = rd_row[k*MASK_WIDTH +: MASK_WIDTH];
      else        mask_new[k] = mask_q[k-1] & rd_row[k*MASK_WIDTH +: MASK_WIDTH];
      if ((CFG_W + 1)'(k + 1) == n_eff) top_mask = mask_new[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_LEVELS; k++) mask_q[k] <= '0;
    end else if (s1_fire) begin
      for (int k = 0; k < MAX_LEVELS; k++) begin
        if (s1_mode_q == MODE_START) begin
          mask_q[k] <= '0;
        end else if ((CFG_W + 1)'(k) < n_eff) begin
          mask_q[k] <= mask_new[k];
        end
      end
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    hit_valid_d = hit_take ? 1'b0 : hit_valid_q;
    if (s1_fire && (s1_mode_q == MODE_SCAN) && (top_mask != '0)) hit_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_valid_q <= 1'b0;
    end else begin
      hit_valid_q <= hit_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && (s1_mode_q == MODE_SCAN) && (top_mask != '0)) begin
      hit_mask_q  <= WORD_W'(top_mask);
      hit_chunk_q <= s1_here_q;
    end
  end

  assign hit_o.valid     = hit_valid_q;
  assign hit_o.hit_mask  = hit_mask_q;
  assign hit_o.hit_chunk = hit_chunk_q;

endmodule
